/* rtl/prosm_pkg.sv */
// shared types, codes and defaults for the per-row ordered set unit
package prosm_pkg;

    localparam int ROWS_DEF  = 8;
    localparam int SLOTS_DEF = 16;
    localparam int PTR_W     = 5;
    localparam int KEY_W     = 8;

    localparam logic [PTR_W-1:0] NIL = 5'd31;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_DEL     = 3'd1;
    localparam logic [2:0] OP_DEL_ALL = 3'd2;
    localparam logic [2:0] OP_CLR     = 3'd3;
    localparam logic [2:0] OP_UPD     = 3'd4;
    localparam logic [2:0] OP_QUERY   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]       op;
        logic [3:0]       row;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic       row_empty;
        logic       row_all_masked;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic walk_start;
        logic rd;
        logic step;
        logic del;
        logic note_hit;
        logic add_new;
        logic add_link;
        logic clr;
        logic upd;
        logic first_row;
        logic row_inc;
        logic restore_row;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       ok;
        logic       key_zero;
        logic       walk_end;
        logic       key_eq;
        logic       head_slot;
        logic       tail_slot;
        logic       pool_full;
        logic       last_row;
        logic       found;
        logic       out_busy;
    } stat_t;

endpackage

/* rtl/prosm_ctrl.sv */
// sequencer for list walks, inserts, deletes, clears, mask updates and result hand-off
module prosm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  prosm_pkg::stat_t st,
    output prosm_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_ROW  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_EVAL = 4'd5;
    localparam logic [3:0] S_ADD1 = 4'd6;
    localparam logic [3:0] S_ADD2 = 4'd7;
    localparam logic [3:0] S_NXT  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       del_op;

    assign req_stall = (state_reg != S_IDLE);
    assign del_op = (st.op == prosm_pkg::OP_DEL) || (st.op == prosm_pkg::OP_DEL_ALL);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (st.op == prosm_pkg::OP_DEL_ALL)
                begin
                    if (st.key_zero)
                    begin
                        cmd.restore_row = 1'b1;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        cmd.first_row = 1'b1;
                        state_next    = S_ROW;
                    end
                end
                else if (!st.ok)
                begin
                    cmd.upd    = (st.op == prosm_pkg::OP_UPD);
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_RD;
                end
            end
            S_ROW:
            begin
                if (st.head_slot)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_RD;
                end
                else
                begin
                    state_next = S_NXT;
                end
            end
            S_RD:
            begin
                if (st.walk_end)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (st.key_eq)
                begin
                    if (del_op && !st.key_zero)
                    begin
                        cmd.del    = 1'b1;
                        state_next = (st.op == prosm_pkg::OP_DEL_ALL) ? S_NXT : S_FIN;
                    end
                    else
                    begin
                        cmd.note_hit = 1'b1;
                        state_next   = S_EVAL;
                    end
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_EVAL:
            begin
                state_next = S_FIN;
                if (st.op == prosm_pkg::OP_ADD)
                begin
                    if (!st.found && !st.key_zero)
                    begin
                        state_next = S_ADD1;
                    end
                end
                else if (st.op == prosm_pkg::OP_CLR)
                begin
                    cmd.clr = 1'b1;
                end
                else if (st.op == prosm_pkg::OP_UPD)
                begin
                    cmd.upd = 1'b1;
                end
                else if (st.op == prosm_pkg::OP_DEL_ALL)
                begin
                    state_next = S_NXT;
                end
            end
            S_ADD1:
            begin
                cmd.add_new = 1'b1;
                state_next  = (!st.pool_full && st.head_slot && st.tail_slot) ? S_ADD2 : S_FIN;
            end
            S_ADD2:
            begin
                cmd.add_link = 1'b1;
                state_next   = S_FIN;
            end
            S_NXT:
            begin
                if (st.last_row)
                begin
                    cmd.restore_row = 1'b1;
                    state_next      = S_FIN;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = S_ROW;
                end
            end
            S_FIN:
            begin
                if (!st.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/prosm_dp.sv */
// slot memory, row pointers, walk registers and result register
module prosm_dp #(
    parameter int ROWS  = prosm_pkg::ROWS_DEF,
    parameter int SLOTS = prosm_pkg::SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  prosm_pkg::req_t  req,
    input  prosm_pkg::cmd_t  cmd,
    output prosm_pkg::stat_t st,
    output prosm_pkg::rsp_t  rsp,
    output logic             rsp_valid,
    input  logic             rsp_stall
);

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH = ROWS * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(SLOTS + 2);
    localparam int PW    = prosm_pkg::PTR_W;
    localparam int KW    = prosm_pkg::KEY_W;
    localparam int MW    = KW + PW;

    localparam logic [PW-1:0] NILP      = prosm_pkg::NIL;
    localparam logic [PW-1:0] SLOTS_P   = PW'(SLOTS);
    localparam logic [NW-1:0] N_DEL_LIM = NW'(SLOTS);
    localparam logic [NW-1:0] N_HAS_LIM = NW'(SLOTS - 1);

    logic [MW-1:0]   mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [PW-1:0]   head_reg [ROWS];
    logic [PW-1:0]   tail_reg [ROWS];
    logic [PW-1:0]   mask_reg [ROWS];

    prosm_pkg::req_t req_reg;
    logic [RW-1:0]   wrow_reg;
    logic [PW-1:0]   cur_reg;
    logic [PW-1:0]   prev_reg;
    logic [KW-1:0]   prev_key_reg;
    logic [NW-1:0]   n_reg;
    logic            found_reg;
    logic            full_reg;
    logic [PW-1:0]   new_reg;
    logic [MW-1:0]   rd_word_reg;
    logic            rd_vld_reg;
    prosm_pkg::rsp_t rsp_reg;
    logic            rsp_valid_reg;

    logic            ok;
    logic            del_op;
    logic [KW-1:0]   rd_key;
    logic [PW-1:0]   rd_next;
    logic [PW-1:0]   head_w;
    logic [PW-1:0]   tail_w;
    logic [PW-1:0]   mask_w;
    logic            head_is;
    logic            tail_is;
    logic            cur_is;
    logic [SLOTS-1:0] row_vld;
    logic [SW-1:0]   free_idx;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [MW-1:0]   wdata;
    logic            re;
    logic [AW-1:0]   raddr;

    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [SW-1:0] s);
        return AW'(r) * AW'(SLOTS) + AW'(s);
    endfunction

    function automatic logic is_slot(input logic [PW-1:0] p);
        return p < SLOTS_P;
    endfunction

    assign ok      = {1'b0, req_reg.row} < 5'(ROWS);
    assign del_op  = (req_reg.op == prosm_pkg::OP_DEL) || (req_reg.op == prosm_pkg::OP_DEL_ALL);
    assign rd_key  = rd_vld_reg ? rd_word_reg[MW-1:PW] : '0;
    assign rd_next = rd_vld_reg ? rd_word_reg[PW-1:0] : NILP;
    assign head_w  = head_reg[wrow_reg];
    assign tail_w  = tail_reg[wrow_reg];
    assign mask_w  = mask_reg[wrow_reg];
    assign head_is = is_slot(head_w);
    assign tail_is = is_slot(tail_w);
    assign cur_is  = is_slot(cur_reg);

    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            row_vld[s] = valid_reg[addr_of(wrow_reg, SW'(s))];
        end
    end

    // lowest free slot of the working row
    always_comb
    begin
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!row_vld[s])
            begin
                free_idx = SW'(s);
            end
        end
    end

    always_comb
    begin
        st           = '0;
        st.op        = req_reg.op;
        st.ok        = ok;
        st.key_zero  = (req_reg.key == '0);
        st.walk_end  = !cur_is || (n_reg > (del_op ? N_DEL_LIM : N_HAS_LIM));
        st.key_eq    = (rd_key == req_reg.key);
        st.head_slot = head_is;
        st.tail_slot = tail_is;
        st.pool_full = &row_vld;
        st.last_row  = (wrow_reg == RW'(ROWS - 1));
        st.found     = found_reg;
        st.out_busy  = rsp_valid_reg && rsp_stall;
    end

    // single write port and single read port on the slot memory
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (cmd.del && (n_reg != '0))
        begin
            we    = 1'b1;
            waddr = addr_of(wrow_reg, prev_reg[SW-1:0]);
            wdata = {prev_key_reg, rd_next};
        end
        else if (cmd.add_new && !(&row_vld))
        begin
            we    = 1'b1;
            waddr = addr_of(wrow_reg, free_idx);
            wdata = {req_reg.key, NILP};
        end
        else if (cmd.add_link)
        begin
            we    = 1'b1;
            waddr = addr_of(wrow_reg, tail_w[SW-1:0]);
            wdata = {rd_key, new_reg};
        end
    end

    always_comb
    begin
        re    = 1'b0;
        raddr = addr_of(wrow_reg, cur_reg[SW-1:0]);
        if (cmd.rd)
        begin
            re = 1'b1;
        end
        else if (cmd.add_new)
        begin
            re    = 1'b1;
            raddr = addr_of(wrow_reg, tail_w[SW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_word_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else if (re)
        begin
            rd_vld_reg <= valid_reg[raddr];
        end
    end

    // walk and request registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req;
            wrow_reg  <= req.row[RW-1:0];
            found_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        if (cmd.first_row)
        begin
            wrow_reg <= '0;
        end
        if (cmd.row_inc)
        begin
            wrow_reg <= wrow_reg + 1'b1;
        end
        if (cmd.restore_row)
        begin
            wrow_reg <= req_reg.row[RW-1:0];
        end
        if (cmd.walk_start)
        begin
            cur_reg  <= head_w;
            prev_reg <= NILP;
            n_reg    <= '0;
        end
        if (cmd.step)
        begin
            prev_reg     <= cur_reg;
            prev_key_reg <= rd_key;
            cur_reg      <= rd_next;
            n_reg        <= n_reg + 1'b1;
        end
        if (cmd.note_hit && (n_reg < N_DEL_LIM))
        begin
            found_reg <= 1'b1;
        end
        if (cmd.del && ((req_reg.op == prosm_pkg::OP_DEL_ALL) || (n_reg < N_DEL_LIM)))
        begin
            found_reg <= 1'b1;
        end
        if (cmd.add_new)
        begin
            full_reg <= &row_vld;
            new_reg  <= PW'(free_idx);
        end
    end

    // occupancy bits and row pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int r = 0; r < ROWS; r++)
            begin
                head_reg[r] <= NILP;
                tail_reg[r] <= NILP;
                mask_reg[r] <= NILP;
            end
        end
        else
        begin
            if (cmd.del)
            begin
                valid_reg[addr_of(wrow_reg, cur_reg[SW-1:0])] <= 1'b0;
                if (n_reg == '0)
                begin
                    head_reg[wrow_reg] <= rd_next;
                    if (tail_w == cur_reg)
                    begin
                        tail_reg[wrow_reg] <= NILP;
                    end
                end
                else if (tail_w == cur_reg)
                begin
                    tail_reg[wrow_reg] <= prev_reg;
                end
                if (mask_w == cur_reg)
                begin
                    mask_reg[wrow_reg] <= rd_next;
                end
            end
            if (cmd.add_new && !(&row_vld))
            begin
                valid_reg[addr_of(wrow_reg, free_idx)] <= 1'b1;
                if (!head_is)
                begin
                    head_reg[wrow_reg] <= PW'(free_idx);
                    tail_reg[wrow_reg] <= PW'(free_idx);
                end
                else if (!tail_is)
                begin
                    tail_reg[wrow_reg] <= PW'(free_idx);
                end
            end
            if (cmd.add_link)
            begin
                tail_reg[wrow_reg] <= new_reg;
            end
            if (cmd.clr)
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    valid_reg[addr_of(wrow_reg, SW'(s))] <= 1'b0;
                end
                head_reg[wrow_reg] <= NILP;
                tail_reg[wrow_reg] <= NILP;
                mask_reg[wrow_reg] <= NILP;
            end
            if (cmd.upd)
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    mask_reg[r] <= tail_reg[r];
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.status         <= !ok ? prosm_pkg::ST_RANGE :
                                      (full_reg ? prosm_pkg::ST_FULL : prosm_pkg::ST_OK);
            rsp_reg.found          <= found_reg;
            rsp_reg.row_empty      <= ok && !head_is;
            rsp_reg.row_all_masked <= ok && (mask_w == tail_w);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

/* rtl/per_row_ordered_set_with_mask_unit.sv */
// top level of the per-row ordered key set with mask pointers
//
// request channel: req_valid / req_stall carry one transaction {op, row, key};
// it is taken at a rising edge with req_valid high and req_stall low.
// result channel: rsp_valid / rsp_stall carry one transaction per request
// {status, found, row_empty, row_all_masked}, in request order.
// one request is worked on at a time; req_stall stays high from acceptance
// until the result has been written to the output register.
// a list walk reads the slot memory, then compares, for each visited slot,
// since the slot memory has a registered read port; add follows the walk
// with a write of the new slot and, when there was room and the row already
// had a tail, a link write; delete-from-all-rows walks every non-empty row in
// turn. a request with row out of range skips the walk, but for that delete.
// when the receiver stalls, the finished result holds in the output register
// and the next request may already be accepted; its result waits for the slot.
// reset clears all row pointers and slot occupancy bits at once, so the
// block takes requests as soon as reset is released.
module per_row_ordered_set_with_mask_unit #(
    parameter int ROWS  = prosm_pkg::ROWS_DEF,
    parameter int SLOTS = prosm_pkg::SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  prosm_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output prosm_pkg::rsp_t rsp
);

    // command and status between sequencer and datapath
    prosm_pkg::cmd_t  cmd;
    prosm_pkg::stat_t st;

    prosm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd)
    );

    prosm_dp #(
        .ROWS  (ROWS),
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .st        (st),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    // an accepted transaction blocks the request side on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request side not busy after accept");

    // status code three is never produced
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status != 2'd3))
        else $error("illegal status code");

    // out-of-range rows report no row flags
    a_range_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == prosm_pkg::ST_RANGE)) |->
        (!rsp.row_empty && !rsp.row_all_masked))
        else $error("row flags set on out-of-range row");

    // a refused add never reports the key as present
    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == prosm_pkg::ST_FULL)) |-> !rsp.found)
        else $error("pool full reported with key present");

endmodule
